/* src/usc_pkg.sv */
// Shared constants and a type for the Unix-seconds-to-calendar converter.
// Holds the reciprocal constants for the divisions and the day split record.
// No dependencies.
`default_nettype none

package usc_pkg;

    localparam logic [25:0] DayRecip    = 26'd50903317;
    localparam logic [9:0]  DayDivOdd   = 10'd675;
    localparam logic [21:0] JdnEpoch    = 22'd2440588;
    localparam logic [23:0] RichB       = 24'd274277;
    localparam logic [24:0] CentRecip   = 25'd30103606;
    localparam logic [21:0] RichJMinusC = 22'd1363;
    localparam logic [24:0] QuadRecip   = 25'd23517960;
    localparam logic [10:0] Days4y      = 11'd1461;
    localparam logic [11:0] MonRecip    = 12'd3427;
    localparam logic [7:0]  RichS       = 8'd153;
    localparam logic [8:0]  FifthRecip  = 9'd410;
    localparam logic [15:0] Recip15     = 16'd34953;
    localparam logic [13:0] RichY       = 14'd4716;
    localparam logic [3:0]  MonthMar    = 4'd3;
    localparam logic [3:0]  MonthWrap   = 4'd10;

    typedef struct packed {
        logic [15:0] days;
        logic [16:0] sod;
    } t_split;

endpackage

`default_nettype wire

/* src/usc_front.sv */
// Front end: accepts timestamps and splits them into whole days and second of day.
// Depends on usc_pkg.
`default_nettype none

module usc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [31:0]     i_unix_seconds,
    output logic                 o_push,
    output usc_pkg::t_split      o_split,
    input  wire logic            i_full
);

    logic            r_v1;
    logic            r_v2;
    logic [50:0]     r_prod;
    logic [24:0]     r_x;
    logic [6:0]      r_lo7;
    usc_pkg::t_split r_split;
    logic            w_adv;
    logic [24:0]     w_x;
    logic [15:0]     w_days;
    logic [24:0]     w_prod675;
    logic [24:0]     w_rem;

    assign w_adv     = !(r_v2 && i_full);
    assign o_stall   = !w_adv;
    assign o_push    = r_v2 && !i_full;
    assign o_split   = r_split;
    assign w_x       = i_unix_seconds[31:7];
    assign w_days    = r_prod[50:35];
    assign w_prod675 = {9'd0, w_days} * {15'd0, usc_pkg::DayDivOdd};
    assign w_rem     = r_x - w_prod675;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod       <= {26'd0, w_x} * {25'd0, usc_pkg::DayRecip};
            r_x          <= w_x;
            r_lo7        <= i_unix_seconds[6:0];
            r_split.days <= w_days;
            r_split.sod  <= {w_rem[9:0], r_lo7};
        end
    end

endmodule

`default_nettype wire

/* src/usc_queue.sv */
// Two-entry queue between the front end and the calendar back end.
// Depends on usc_pkg.
`default_nettype none

module usc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire usc_pkg::t_split i_data,
    output logic                 o_full,
    output logic                 o_valid,
    output usc_pkg::t_split      o_data,
    input  wire logic            i_pop
);

    usc_pkg::t_split r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            w_pop;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* src/usc_back.sv */
// Back end: turns whole days into a Gregorian date and second of day into time.
// Depends on usc_pkg.
`default_nettype none

module usc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_head_valid,
    input  wire usc_pkg::t_split i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [11:0]          o_year,
    output logic [3:0]           o_month,
    output logic [4:0]           o_day,
    output logic [4:0]           o_hour,
    output logic [5:0]           o_minute,
    output logic [5:0]           o_second
);

    logic        w_adv;
    logic [7:1]  r_v;
    logic        r_out_valid;

    logic [48:0] r1_prod;
    logic [21:0] r1_jdn;
    logic [16:0] r1_sod;
    logic [30:0] r1_tprod;

    logic [23:0] r2_e;
    logic [10:0] r2_tm;
    logic [5:0]  r2_sec;

    logic [48:0] r3_prod;
    logic [23:0] r3_e;
    logic [24:0] r3_hprod;
    logic [10:0] r3_tm;
    logic [5:0]  r3_sec;

    logic [10:0] r4_h;
    logic [13:0] r4_qy;
    logic [4:0]  r4_hour;
    logic [5:0]  r4_min;
    logic [5:0]  r4_sec;

    logic [22:0] r5_mprod;
    logic [10:0] r5_h;
    logic [13:0] r5_qy;
    logic [4:0]  r5_hour;
    logic [5:0]  r5_min;
    logic [5:0]  r5_sec;

    logic [7:0]  r6_hr;
    logic [3:0]  r6_month;
    logic [11:0] r6_year;
    logic [4:0]  r6_hour;
    logic [5:0]  r6_min;
    logic [5:0]  r6_sec;

    logic [15:0] r7_dprod;
    logic [3:0]  r7_month;
    logic [11:0] r7_year;
    logic [4:0]  r7_hour;
    logic [5:0]  r7_min;
    logic [5:0]  r7_sec;

    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    logic [5:0]  r_sec;

    logic [21:0] w_jdn;
    logic [23:0] w_a;
    logic [6:0]  w_qc;
    logic [8:0]  w_qc3;
    logic [21:0] w_f;
    logic [10:0] w_tm;
    logic [16:0] w_tm60;
    logic [16:0] w_sec17;
    logic [13:0] w_qy;
    logic [23:0] w_q1461;
    logic [23:0] w_rem;
    logic [8:0]  w_g;
    logic [10:0] w_h;
    logic [4:0]  w_hour;
    logic [10:0] w_h60;
    logic [10:0] w_min11;
    logic [3:0]  w_qm;
    logic [10:0] w_q153;
    logic [10:0] w_hr11;
    logic [3:0]  w_month;
    logic [13:0] w_year;

    assign w_adv = !r_out_valid || !i_stall;
    assign o_pop = w_adv && i_head_valid;

    assign w_jdn   = {6'd0, i_head.days} + usc_pkg::JdnEpoch;
    assign w_a     = {w_jdn, 2'b00} + usc_pkg::RichB;

    assign w_qc    = r1_prod[48:42];
    assign w_qc3   = {2'd0, w_qc} + {1'b0, w_qc, 1'b0};
    assign w_f     = r1_jdn + {15'd0, w_qc3[8:2]} + usc_pkg::RichJMinusC;
    assign w_tm    = r1_tprod[29:19];
    assign w_tm60  = {6'd0, w_tm} * 17'd60;
    assign w_sec17 = r1_sod - w_tm60;

    assign w_qy    = r3_prod[48:35];
    assign w_q1461 = {10'd0, w_qy} * {13'd0, usc_pkg::Days4y};
    assign w_rem   = r3_e - w_q1461;
    assign w_g     = w_rem[10:2];
    assign w_h     = {w_g, 2'b00} + {2'd0, w_g} + 11'd2;
    assign w_hour  = r3_hprod[23:19];
    assign w_h60   = {6'd0, w_hour} * 11'd60;
    assign w_min11 = r3_tm - w_h60;

    assign w_qm    = r5_mprod[22:19];
    assign w_q153  = {7'd0, w_qm} * {3'd0, usc_pkg::RichS};
    assign w_hr11  = r5_h - w_q153;
    assign w_month = (w_qm >= usc_pkg::MonthWrap) ? (w_qm - 4'd9) : (w_qm + usc_pkg::MonthMar);
    assign w_year  = r5_qy - usc_pkg::RichY + {13'd0, (w_month < usc_pkg::MonthMar)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v         <= {r_v[6:1], i_head_valid};
            r_out_valid <= r_v[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_prod  <= {25'd0, w_a} * {24'd0, usc_pkg::CentRecip};
            r1_jdn   <= w_jdn;
            r1_sod   <= i_head.sod;
            r1_tprod <= {16'd0, i_head.sod[16:2]} * {15'd0, usc_pkg::Recip15};

            r2_e     <= {w_f, 2'b11};
            r2_tm    <= w_tm;
            r2_sec   <= w_sec17[5:0];

            r3_prod  <= {25'd0, r2_e} * {24'd0, usc_pkg::QuadRecip};
            r3_e     <= r2_e;
            r3_hprod <= {16'd0, r2_tm[10:2]} * {9'd0, usc_pkg::Recip15};
            r3_tm    <= r2_tm;
            r3_sec   <= r2_sec;

            r4_h     <= w_h;
            r4_qy    <= w_qy;
            r4_hour  <= w_hour;
            r4_min   <= w_min11[5:0];
            r4_sec   <= r3_sec;

            r5_mprod <= {12'd0, r4_h} * {11'd0, usc_pkg::MonRecip};
            r5_h     <= r4_h;
            r5_qy    <= r4_qy;
            r5_hour  <= r4_hour;
            r5_min   <= r4_min;
            r5_sec   <= r4_sec;

            r6_hr    <= w_hr11[7:0];
            r6_month <= w_month;
            r6_year  <= w_year[11:0];
            r6_hour  <= r5_hour;
            r6_min   <= r5_min;
            r6_sec   <= r5_sec;

            r7_dprod <= {8'd0, r6_hr} * {7'd0, usc_pkg::FifthRecip};
            r7_month <= r6_month;
            r7_year  <= r6_year;
            r7_hour  <= r6_hour;
            r7_min   <= r6_min;
            r7_sec   <= r6_sec;

            r_year   <= r7_year;
            r_month  <= r7_month;
            r_day    <= r7_dprod[15:11] + 5'd1;
            r_hour   <= r7_hour;
            r_min    <= r7_min;
            r_sec    <= r7_sec;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_year   = r_year;
    assign o_month  = r_month;
    assign o_day    = r_day;
    assign o_hour   = r_hour;
    assign o_minute = r_min;
    assign o_second = r_sec;

endmodule

`default_nettype wire

/* src/unix_seconds_to_calendar_top.sv */
// Unix seconds to Gregorian date and time of day, top level.
// Accepts one request per cycle while nothing stalls, carried by two multiply stages in the front
// end, a two-entry queue and eight register stages in the back end.
// Reset is synchronous and active low; it clears valid bits and queue pointers and count only.
// Depends on usc_pkg, usc_front, usc_queue and usc_back.
`default_nettype none

module unix_seconds_to_calendar_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_unix_seconds,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second
);

    logic            w_push;
    logic            w_full;
    logic            w_head_valid;
    logic            w_pop;
    usc_pkg::t_split w_split;
    usc_pkg::t_split w_head;

    usc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_unix_seconds (i_unix_seconds),
        .o_push         (w_push),
        .o_split        (w_split),
        .i_full         (w_full)
    );

    usc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_split),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_data  (w_head),
        .i_pop   (w_pop)
    );

    usc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_year       (o_year),
        .o_month      (o_month),
        .o_day        (o_day),
        .o_hour       (o_hour),
        .o_minute     (o_minute),
        .o_second     (o_second)
    );

endmodule

`default_nettype wire
